>>> rtl/core/rps_pkg.sv
// Shared types, codes and the microcode table of the random pick set.
package rps_pkg;

  localparam int unsigned KEY_IN_W    = 32;
  localparam int unsigned RAND_W      = 16;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned UPC_W       = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_PICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_SCAN,
    IDX_LAST,
    IDX_REM
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_EMPTY,
    C_FULL,
    C_MATCH,
    C_SCAN,
    C_REQ_INS,
    C_REQ_DEL,
    C_REQ_PICK,
    C_REQ_NONE,
    C_MOD_DONE,
    C_OUT_FREE
  } cond_e;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath control word.
  typedef struct packed {
    logic    in_ready;
    idx_op_e idx_op;
    logic    mem_we;
    logic    wr_move;
    cnt_op_e cnt_op;
    logic    pos_ld;
    logic    mod_start;
    logic    fin;
    status_e fin_status;
    logic    fin_pick;
  } ctrl_t;

  // Datapath conditions seen by the sequencer.
  typedef struct packed {
    logic accept;
    req_e req;
    logic empty;
    logic full;
    logic match;
    logic last;
    logic mod_done;
    logic out_free;
  } flags_t;

  typedef struct packed {
    cond_e cond;
    upc_t  target;
    logic  wait_else;
    ctrl_t ctrl;
  } uword_t;

  localparam ctrl_t CTRL_NOP = '{
    in_ready:   1'b0,
    idx_op:     IDX_HOLD,
    mem_we:     1'b0,
    wr_move:    1'b0,
    cnt_op:     CNT_HOLD,
    pos_ld:     1'b0,
    mod_start:  1'b0,
    fin:        1'b0,
    fin_status: ST_OK,
    fin_pick:   1'b0
  };

  // Program labels.
  localparam upc_t S_IDLE       = 5'd0;
  localparam upc_t S_CHK_EMPTY  = 5'd1;
  localparam upc_t S_CHK_PICK   = 5'd2;
  localparam upc_t S_CHK_NONE   = 5'd3;
  localparam upc_t S_SCAN       = 5'd4;
  localparam upc_t S_CHK_HIT    = 5'd5;
  localparam upc_t S_CHK_DEL    = 5'd6;
  localparam upc_t S_APPEND     = 5'd7;
  localparam upc_t S_WRITE_NEW  = 5'd8;
  localparam upc_t S_FOUND      = 5'd9;
  localparam upc_t S_TAKE_LAST  = 5'd10;
  localparam upc_t S_MOVE       = 5'd11;
  localparam upc_t S_EMPTY_INS  = 5'd12;
  localparam upc_t S_EMPTY_DEL  = 5'd13;
  localparam upc_t S_EMPTY_PICK = 5'd14;
  localparam upc_t S_EMPTY_NONE = 5'd15;
  localparam upc_t S_PICK       = 5'd16;
  localparam upc_t S_MOD_WAIT   = 5'd17;
  localparam upc_t S_PICK_READ  = 5'd18;
  localparam upc_t S_FIN_PICK   = 5'd19;
  localparam upc_t S_FIN_OK     = 5'd20;
  localparam upc_t S_FIN_DUP    = 5'd21;
  localparam upc_t S_FIN_MISS   = 5'd22;
  localparam upc_t S_FIN_EMPTY  = 5'd23;
  localparam upc_t S_FIN_FULL   = 5'd24;

  // Control store. When the condition fails the step counter either moves on
  // or, with wait_else set, stays put.
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w.cond      = C_ALWAYS;
    w.target    = pc + 1'b1;
    w.wait_else = 1'b0;
    w.ctrl      = CTRL_NOP;
    unique case (pc)
      S_IDLE: begin
        w.cond          = C_ACCEPT;
        w.target        = S_CHK_EMPTY;
        w.wait_else     = 1'b1;
        w.ctrl.in_ready = 1'b1;
        w.ctrl.idx_op   = IDX_CLEAR;
      end
      S_CHK_EMPTY: begin
        w.cond   = C_EMPTY;
        w.target = S_EMPTY_INS;
      end
      S_CHK_PICK: begin
        w.cond   = C_REQ_PICK;
        w.target = S_PICK;
      end
      S_CHK_NONE: begin
        w.cond   = C_REQ_NONE;
        w.target = S_FIN_OK;
      end
      S_SCAN: begin
        w.cond        = C_SCAN;
        w.target      = S_SCAN;
        w.ctrl.idx_op = IDX_SCAN;
      end
      S_CHK_HIT: begin
        w.cond   = C_MATCH;
        w.target = S_FOUND;
      end
      S_CHK_DEL: begin
        w.cond   = C_REQ_DEL;
        w.target = S_FIN_MISS;
      end
      S_APPEND: begin
        w.cond   = C_FULL;
        w.target = S_FIN_FULL;
      end
      S_WRITE_NEW: begin
        w.target      = S_FIN_OK;
        w.ctrl.mem_we = 1'b1;
        w.ctrl.cnt_op = CNT_INC;
      end
      S_FOUND: begin
        w.cond   = C_REQ_INS;
        w.target = S_FIN_DUP;
      end
      S_TAKE_LAST: begin
        w.ctrl.pos_ld = 1'b1;
        w.ctrl.idx_op = IDX_LAST;
        w.ctrl.cnt_op = CNT_DEC;
      end
      S_MOVE: begin
        w.target       = S_FIN_OK;
        w.ctrl.mem_we  = 1'b1;
        w.ctrl.wr_move = 1'b1;
      end
      S_EMPTY_INS: begin
        w.cond   = C_REQ_INS;
        w.target = S_APPEND;
      end
      S_EMPTY_DEL: begin
        w.cond   = C_REQ_DEL;
        w.target = S_FIN_MISS;
      end
      S_EMPTY_PICK: begin
        w.cond   = C_REQ_PICK;
        w.target = S_FIN_EMPTY;
      end
      S_EMPTY_NONE: begin
        w.target = S_FIN_OK;
      end
      S_PICK: begin
        w.ctrl.mod_start = 1'b1;
      end
      S_MOD_WAIT: begin
        w.cond      = C_MOD_DONE;
        w.target    = S_PICK_READ;
        w.wait_else = 1'b1;
      end
      S_PICK_READ: begin
        w.ctrl.idx_op = IDX_REM;
      end
      S_FIN_PICK: begin
        w.cond          = C_OUT_FREE;
        w.target        = S_IDLE;
        w.wait_else     = 1'b1;
        w.ctrl.fin      = 1'b1;
        w.ctrl.fin_pick = 1'b1;
      end
      S_FIN_OK: begin
        w.cond      = C_OUT_FREE;
        w.target    = S_IDLE;
        w.wait_else = 1'b1;
        w.ctrl.fin  = 1'b1;
      end
      S_FIN_DUP: begin
        w.cond            = C_OUT_FREE;
        w.target          = S_IDLE;
        w.wait_else       = 1'b1;
        w.ctrl.fin        = 1'b1;
        w.ctrl.fin_status = ST_DUP;
      end
      S_FIN_MISS: begin
        w.cond            = C_OUT_FREE;
        w.target          = S_IDLE;
        w.wait_else       = 1'b1;
        w.ctrl.fin        = 1'b1;
        w.ctrl.fin_status = ST_MISSING;
      end
      S_FIN_EMPTY: begin
        w.cond            = C_OUT_FREE;
        w.target          = S_IDLE;
        w.wait_else       = 1'b1;
        w.ctrl.fin        = 1'b1;
        w.ctrl.fin_status = ST_EMPTY;
      end
      S_FIN_FULL: begin
        w.cond            = C_OUT_FREE;
        w.target          = S_IDLE;
        w.wait_else       = 1'b1;
        w.ctrl.fin        = 1'b1;
        w.ctrl.fin_status = ST_FULL;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/rps_mod.sv
// Bit-serial restoring remainder unit: random value modulo the live count.
module rps_mod import rps_pkg::*; #(
  parameter int unsigned DIV_W = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAND_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  localparam int unsigned STEP_W = $clog2(RAND_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RAND_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;

  assign shifted = {rem_q, dvd_q[RAND_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = STEP_W'(RAND_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[RAND_W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d = diff[DIV_W-1:0];
      end else begin
        rem_d = shifted[DIV_W-1:0];
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q && !busy_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/rps_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
module rps_seq import rps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  upc_t   upc_q, upc_d;
  uword_t uword;
  logic   taken;

  assign uword  = ucode(upc_q);
  assign ctrl_o = uword.ctrl;

  always_comb begin
    unique case (uword.cond)
      C_ALWAYS:   taken = 1'b1;
      C_ACCEPT:   taken = flags_i.accept;
      C_EMPTY:    taken = flags_i.empty;
      C_FULL:     taken = flags_i.full;
      C_MATCH:    taken = flags_i.match;
      C_SCAN:     taken = !flags_i.match && !flags_i.last;
      C_REQ_INS:  taken = (flags_i.req == REQ_INSERT);
      C_REQ_DEL:  taken = (flags_i.req == REQ_DELETE);
      C_REQ_PICK: taken = (flags_i.req == REQ_PICK);
      C_REQ_NONE: taken = (flags_i.req == REQ_NONE);
      C_MOD_DONE: taken = flags_i.mod_done;
      C_OUT_FREE: taken = flags_i.out_free;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      upc_d = uword.target;
    end else if (uword.wait_else) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/core/rps_dp.sv
// Datapath: request registers, slot memory, live count, index and result register.
module rps_dp import rps_pkg::*; #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_t                  ctrl_i,
  output flags_t                 flags_o,
  input  logic                   in_valid_i,
  input  logic [1:0]             req_type_i,
  input  logic [KEY_IN_W-1:0]    key_i,
  input  logic [RAND_W-1:0]      rand_value_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [KEY_IN_W-1:0]    key_out_o,
  output logic [2:0]             status_o,
  output logic [COUNT_OUT_W-1:0] count_after_o
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CXW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  logic                   accept;
  req_e                   req_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [RAND_W-1:0]      rand_q;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          count_m1;
  logic [IW-1:0]          idx_q, idx_d;
  logic [IW-1:0]          pos_q;
  logic [KEY_WIDTH-1:0]   mem [CAPACITY];
  logic [KEY_WIDTH-1:0]   rdata_q;
  logic [IW-1:0]          wr_addr;
  logic [KEY_WIDTH-1:0]   wr_data;
  logic [63:0]            key_x;
  logic [63:0]            rd_x;
  logic [CXW-1:0]         cnt_x;
  logic                   match, last, empty, full;
  logic                   mod_done;
  logic [CW-1:0]          rem;
  logic                   out_free, out_load;
  logic                   out_valid_q;
  logic [KEY_IN_W-1:0]    key_out_q;
  status_e                status_q;
  logic [COUNT_OUT_W-1:0] count_after_q;

  assign accept = in_valid_i && ctrl_i.in_ready;

  // Keys are kept at KEY_WIDTH bits; extend through 64-bit words so widths up to 64 bits work.
  always_comb begin
    key_x            = '0;
    key_x[KEY_IN_W-1:0] = key_i;
    rd_x             = '0;
    rd_x[KEY_WIDTH-1:0] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_e'(req_type_i);
      key_q  <= key_x[KEY_WIDTH-1:0];
      rand_q <= rand_value_i;
    end
  end

  assign count_m1 = count_q - 1'b1;
  assign match    = (rdata_q == key_q);
  assign last     = (CW'(idx_q) == count_m1);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(CAPACITY));

  always_comb begin
    unique case (ctrl_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_CLEAR: idx_d = '0;
      IDX_SCAN:  idx_d = (!match && !last) ? idx_q + 1'b1 : idx_q;
      IDX_LAST:  idx_d = count_m1[IW-1:0];
      IDX_REM:   idx_d = rem[IW-1:0];
      default:   idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.cnt_op)
      CNT_INC: count_d = count_q + 1'b1;
      CNT_DEC: count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pos_ld) begin
      pos_q <= idx_q;
    end
  end

  // The read address follows the next index, so rdata_q always holds slot idx_q.
  assign wr_addr = ctrl_i.wr_move ? pos_q : count_q[IW-1:0];
  assign wr_data = ctrl_i.wr_move ? rdata_q : key_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[idx_d];
  end

  rps_mod #(
    .DIV_W(CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.mod_start),
    .dividend_i (rand_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  // Result register: a finished item can wait here while the next is accepted.
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ctrl_i.fin && out_free;
  assign cnt_x    = CXW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      key_out_q     <= ctrl_i.fin_pick ? rd_x[KEY_IN_W-1:0] : '0;
      status_q      <= ctrl_i.fin_status;
      count_after_q <= cnt_x[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_out_o     = key_out_q;
  assign status_o      = status_q;
  assign count_after_o = count_after_q;

  assign flags_o = '{
    accept:   accept,
    req:      req_q,
    empty:    empty,
    full:     full,
    match:    match,
    last:     last,
    mod_done: mod_done,
    out_free: out_free
  };

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("live count beyond capacity");

  a_append_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.mem_we && !ctrl_i.wr_move |-> !full)
    else $error("append into a full store");

  a_scan_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.idx_op == IDX_SCAN || ctrl_i.mod_start || ctrl_i.cnt_op == CNT_DEC |-> !empty)
    else $error("scan, pick or delete on an empty store");

  a_dec_updates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cnt_op == CNT_DEC |=> count_q == $past(count_q) - 1'b1)
    else $error("delete did not shrink the live count");

endmodule

>>> rtl/core/random_pick_set.sv
// Random pick set: a set of distinct keys with insert, delete and random pick.
//
// One request item enters on the input channel (req_type_i, key_i, rand_value_i)
// and exactly one result item leaves on the output channel (key_out_o, status_o,
// count_after_o). Both channels are valid/ready.
// A microcoded sequencer steps through a short program per request. Insert and
// delete scan the live slots one slot per cycle through the slot memory's read
// port. Pick runs a bit-serial remainder of the 16-bit random value, one bit a
// cycle. Requests on an empty set and unused request codes finish without a
// scan; a duplicate, missing or full case still scans.
// One request is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register.
// If the receiver stalls, the result is held in the output register and a
// further request runs up to its final step and waits there.
// Reset empties the set (live count zero) and clears the output valid; the
// slot memory is not cleared, since only live slots are ever read.
module random_pick_set import rps_pkg::*; #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [KEY_IN_W-1:0]    key_i,
  input  logic [RAND_W-1:0]      rand_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [KEY_IN_W-1:0]    key_out_o,
  output logic [2:0]             status_o,
  output logic [COUNT_OUT_W-1:0] count_after_o
);

  ctrl_t  ctrl;
  flags_t flags;

  rps_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  rps_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .flags_o       (flags),
    .in_valid_i    (in_valid_i),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .rand_value_i  (rand_value_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .key_out_o     (key_out_o),
    .status_o      (status_o),
    .count_after_o (count_after_o)
  );

  assign in_ready_o = ctrl.in_ready;

endmodule
